// ----- hw/rtl/cpu8_ex_pkg.sv -----
// ============================================================================
// cpu8_ex_pkg
// Shared types and constants for the 8-bit CPU execute unit: command codes,
// field widths and the entry that travels from the front to the back.
// ============================================================================
package cpu8_ex_pkg;

    localparam int CMD_W       = 5;
    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = 16;
    localparam int QUOT_W      = 8;
    localparam int MEM_DEPTH_DEFAULT = 65536;

    localparam logic [7:0] FLAG_C      = 8'b0000_0001;
    localparam logic [7:0] FLAG_Z      = 8'b0000_0010;
    localparam logic [7:0] FLAG_V      = 8'b0100_0000;
    localparam logic [7:0] FLAG_N      = 8'b1000_0000;
    localparam logic [7:0] FLAG_BRK    = 8'b0011_0000;
    localparam logic [7:0] PULL_MASK   = 8'b1100_1111;
    localparam logic [7:0] STATUS_ONE  = 8'b0010_0000;
    localparam logic [7:0] STATUS_RST  = 8'h20;
    localparam logic [7:0] STACK_RST   = 8'hff;

    typedef enum logic [CMD_W-1:0] {
        CMD_LDA = 5'd0,  CMD_LDX = 5'd1,  CMD_LDY = 5'd2,  CMD_STA = 5'd3,
        CMD_STX = 5'd4,  CMD_STY = 5'd5,  CMD_TAX = 5'd6,  CMD_TAY = 5'd7,
        CMD_TSX = 5'd8,  CMD_TXA = 5'd9,  CMD_TXS = 5'd10, CMD_TYA = 5'd11,
        CMD_PHA = 5'd12, CMD_PHP = 5'd13, CMD_PLA = 5'd14, CMD_PLP = 5'd15,
        CMD_DEC = 5'd16, CMD_DEX = 5'd17, CMD_DEY = 5'd18, CMD_INC = 5'd19,
        CMD_INX = 5'd20, CMD_INY = 5'd21, CMD_ADC = 5'd22, CMD_SBC = 5'd23,
        CMD_AND = 5'd24, CMD_EOR = 5'd25, CMD_NOP = 5'd31
    } cmd_t;

    typedef struct packed {
        cmd_t              op;
        logic              mem_read;
        logic [BYTE_W-1:0] value;
        logic [ADDR_W-1:0] address;
        logic [QUOT_W-1:0] addr_quot;
    } entry_t;

endpackage

// ----- hw/rtl/cpu8_ex_if.sv -----
// ============================================================================
// cpu8_ex_if
// Valid/ready channels: command words in, register snapshot words out.
// ============================================================================
interface cpu8_ex_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [cpu8_ex_pkg::CMD_W-1:0]  command;
    logic [cpu8_ex_pkg::BYTE_W-1:0] value;
    logic [cpu8_ex_pkg::ADDR_W-1:0] address;

    modport source (output valid, output command, output value, output address,
                    input ready);
    modport sink   (input valid, input command, input value, input address,
                    output ready);
endinterface

interface cpu8_ex_res_if;
    logic                           valid;
    logic                           ready;
    logic [cpu8_ex_pkg::BYTE_W-1:0] reg_a;
    logic [cpu8_ex_pkg::BYTE_W-1:0] reg_x;
    logic [cpu8_ex_pkg::BYTE_W-1:0] reg_y;
    logic [cpu8_ex_pkg::BYTE_W-1:0] stack_ptr;
    logic [cpu8_ex_pkg::BYTE_W-1:0] status;
    logic                           mem_touched;
    logic [cpu8_ex_pkg::BYTE_W-1:0] mem_byte;

    modport source (output valid, output reg_a, output reg_x, output reg_y,
                    output stack_ptr, output status, output mem_touched,
                    output mem_byte, input ready);
    modport sink   (input valid, input reg_a, input reg_x, input reg_y,
                    input stack_ptr, input status, input mem_touched,
                    input mem_byte, output ready);
endinterface

// ----- hw/rtl/cpu8_ex_front.sv -----
// ============================================================================
// cpu8_ex_front
// Accept command words, classify them and pre-reduce the address quotient.
// ============================================================================
module cpu8_ex_front #(
    parameter int MEM_DEPTH = cpu8_ex_pkg::MEM_DEPTH_DEFAULT
) (
    cpu8_ex_cmd_if.sink          cmd,
    input  logic                 q_full,
    input  logic                 clearing,
    output logic                 push,
    output cpu8_ex_pkg::entry_t  push_entry
);
    import cpu8_ex_pkg::*;

    localparam int SHIFT   = ADDR_W + $clog2(MEM_DEPTH);
    localparam int RECIP_W = 18;
    localparam int PROD_W  = ADDR_W + RECIP_W;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(MEM_DEPTH) - 64'd1) / 64'(MEM_DEPTH);

    logic [PROD_W-1:0] quot_prod;
    cmd_t              op;

    // address / MEM_DEPTH by reciprocal multiply, exact for 16-bit addresses
    assign quot_prod = PROD_W'(cmd.address) * PROD_W'(RECIP);

    always_comb
    begin
        if (cmd.command > CMD_EOR)
            op = CMD_NOP;
        else
            op = cmd_t'(cmd.command);
    end

    assign cmd.ready            = !q_full && !clearing;
    assign push                 = cmd.valid && cmd.ready;
    assign push_entry.op        = op;
    assign push_entry.mem_read  = (op == CMD_PLA) || (op == CMD_PLP) ||
                                  (op == CMD_INC) || (op == CMD_DEC);
    assign push_entry.value     = cmd.value;
    assign push_entry.address   = cmd.address;
    assign push_entry.addr_quot = QUOT_W'(quot_prod >> SHIFT);

endmodule

// ----- hw/rtl/cpu8_ex_queue.sv -----
// ============================================================================
// cpu8_ex_queue
// Two-entry queue between front and back.
// ============================================================================
module cpu8_ex_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cpu8_ex_pkg::entry_t  push_entry,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output cpu8_ex_pkg::entry_t  head
);
    import cpu8_ex_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && full |-> pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue pop while empty");

endmodule

// ----- hw/rtl/cpu8_ex_back.sv -----
// ============================================================================
// cpu8_ex_back
// Execute queued commands against A, X, Y, SP, P and the byte memory; hold
// the result word in an output register.
// ============================================================================
module cpu8_ex_back #(
    parameter int MEM_DEPTH = cpu8_ex_pkg::MEM_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  cpu8_ex_pkg::entry_t  q_entry,
    output logic                 pop,
    output logic                 clearing,
    cpu8_ex_res_if.source        res
);
    import cpu8_ex_pkg::*;

    localparam int AW   = $clog2(MEM_DEPTH);
    localparam int QD_W = 24;

    function automatic logic [7:0] set_zn(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] r;
        r = p & ~(FLAG_Z | FLAG_N);
        if (v == 8'd0)
            r = r | FLAG_Z;
        r = r | (v & FLAG_N);
        return r;
    endfunction

    logic [7:0] mem [MEM_DEPTH];
    logic [7:0] rdata_reg;

    logic [7:0] a_reg, x_reg, y_reg, sp_reg, p_reg;
    logic [7:0] a_next, x_next, y_next, sp_next, p_next;
    logic       wrote;
    logic [7:0] wbyte;

    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          wait_reg;
    entry_t        cur_reg;
    entry_t        ex;

    logic          out_valid_reg;
    logic [7:0]    out_a_reg, out_x_reg, out_y_reg, out_sp_reg, out_p_reg;
    logic          out_touched_reg;
    logic [7:0]    out_byte_reg;

    logic          can_finish;
    logic          finish;
    logic          issue;
    logic [QD_W-1:0] qd_prod;
    logic [QD_W-1:0] rem_full;
    logic [AW-1:0] data_addr;
    logic [AW-1:0] push_addr;
    logic [AW-1:0] pull_addr;
    logic [AW-1:0] mem_addr;
    logic [8:0]    sum9;
    logic [7:0]    addend;

    assign can_finish = !out_valid_reg || res.ready;
    assign ex         = wait_reg ? cur_reg : q_entry;
    assign finish     = !clearing_reg && can_finish &&
                        (wait_reg || (q_valid && !q_entry.mem_read));
    assign issue      = !clearing_reg && !wait_reg && q_valid && q_entry.mem_read;
    assign pop        = issue || (finish && !wait_reg);
    assign clearing   = clearing_reg;

    // address mod MEM_DEPTH from the front's quotient
    assign qd_prod   = QD_W'(ex.addr_quot) * QD_W'(MEM_DEPTH);
    assign rem_full  = QD_W'(ex.address) - qd_prod;
    assign data_addr = rem_full[AW-1:0];
    assign push_addr = AW'({1'b1, sp_reg});
    assign pull_addr = AW'({1'b1, sp_reg + 8'd1});

    always_comb
    begin
        case (ex.op)
            CMD_PHA, CMD_PHP: mem_addr = push_addr;
            CMD_PLA, CMD_PLP: mem_addr = pull_addr;
            default:          mem_addr = data_addr;
        endcase
    end

    assign addend = (ex.op == CMD_SBC) ? ~ex.value : ex.value;
    assign sum9   = {1'b0, a_reg} + {1'b0, addend} + {8'd0, p_reg[0]};

    always_comb
    begin
        a_next  = a_reg;
        x_next  = x_reg;
        y_next  = y_reg;
        sp_next = sp_reg;
        p_next  = p_reg;
        wrote   = 1'b0;
        wbyte   = 8'd0;
        case (ex.op)
            CMD_LDA: begin a_next = ex.value; p_next = set_zn(p_reg, ex.value); end
            CMD_LDX: begin x_next = ex.value; p_next = set_zn(p_reg, ex.value); end
            CMD_LDY: begin y_next = ex.value; p_next = set_zn(p_reg, ex.value); end
            CMD_STA: begin wbyte = a_reg; wrote = 1'b1; end
            CMD_STX: begin wbyte = x_reg; wrote = 1'b1; end
            CMD_STY: begin wbyte = y_reg; wrote = 1'b1; end
            CMD_TAX: begin x_next = a_reg; p_next = set_zn(p_reg, a_reg); end
            CMD_TAY: begin y_next = a_reg; p_next = set_zn(p_reg, a_reg); end
            CMD_TSX: begin x_next = sp_reg; p_next = set_zn(p_reg, sp_reg); end
            CMD_TXA: begin a_next = x_reg; p_next = set_zn(p_reg, x_reg); end
            CMD_TXS: sp_next = x_reg;
            CMD_TYA: begin a_next = y_reg; p_next = set_zn(p_reg, y_reg); end
            CMD_PHA:
            begin
                wbyte   = a_reg;
                wrote   = 1'b1;
                sp_next = sp_reg - 8'd1;
            end
            CMD_PHP:
            begin
                wbyte   = p_reg | FLAG_BRK;
                wrote   = 1'b1;
                sp_next = sp_reg - 8'd1;
            end
            CMD_PLA:
            begin
                sp_next = sp_reg + 8'd1;
                a_next  = rdata_reg;
                p_next  = set_zn(p_reg, rdata_reg);
            end
            CMD_PLP:
            begin
                sp_next = sp_reg + 8'd1;
                p_next  = (rdata_reg & PULL_MASK) | STATUS_ONE;
            end
            CMD_DEC:
            begin
                wbyte  = rdata_reg - 8'd1;
                wrote  = 1'b1;
                p_next = set_zn(p_reg, rdata_reg - 8'd1);
            end
            CMD_DEX: begin x_next = x_reg - 8'd1; p_next = set_zn(p_reg, x_reg - 8'd1); end
            CMD_DEY: begin y_next = y_reg - 8'd1; p_next = set_zn(p_reg, y_reg - 8'd1); end
            CMD_INC:
            begin
                wbyte  = rdata_reg + 8'd1;
                wrote  = 1'b1;
                p_next = set_zn(p_reg, rdata_reg + 8'd1);
            end
            CMD_INX: begin x_next = x_reg + 8'd1; p_next = set_zn(p_reg, x_reg + 8'd1); end
            CMD_INY: begin y_next = y_reg + 8'd1; p_next = set_zn(p_reg, y_reg + 8'd1); end
            CMD_ADC, CMD_SBC:
            begin
                a_next = sum9[7:0];
                p_next = p_reg & ~(FLAG_C | FLAG_V);
                if (sum9[8])
                    p_next = p_next | FLAG_C;
                if ((~(a_reg[7] ^ addend[7]) & (a_reg[7] ^ sum9[7])) == 1'b1)
                    p_next = p_next | FLAG_V;
                p_next = set_zn(p_next, sum9[7:0]);
            end
            CMD_AND:
            begin
                a_next = a_reg & ex.value;
                p_next = set_zn(p_reg, a_reg & ex.value);
            end
            CMD_EOR:
            begin
                a_next = a_reg ^ ex.value;
                p_next = set_zn(p_reg, a_reg ^ ex.value);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg         <= 8'd0;
            x_reg         <= 8'd0;
            y_reg         <= 8'd0;
            sp_reg        <= STACK_RST;
            p_reg         <= STATUS_RST;
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            wait_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(MEM_DEPTH - 1))
                    clearing_reg <= 1'b0;
            end
            if (issue)
                wait_reg <= 1'b1;
            else if (finish)
                wait_reg <= 1'b0;
            if (finish)
            begin
                a_reg  <= a_next;
                x_reg  <= x_next;
                y_reg  <= y_next;
                sp_reg <= sp_next;
                p_reg  <= p_next;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers: entry held across a memory read, result word
    always_ff @(posedge clk)
    begin
        if (issue)
            cur_reg <= q_entry;
        if (finish)
        begin
            out_a_reg       <= a_next;
            out_x_reg       <= x_next;
            out_y_reg       <= y_next;
            out_sp_reg      <= sp_next;
            out_p_reg       <= p_next;
            out_touched_reg <= wrote;
            out_byte_reg    <= wbyte;
        end
    end

    // byte memory: one write port (clear sweep or execute), one registered read
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            mem[clr_cnt_reg] <= 8'd0;
        else if (finish && wrote)
            mem[mem_addr] <= wbyte;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
            rdata_reg <= mem[mem_addr];
    end

    assign res.valid       = out_valid_reg;
    assign res.reg_a       = out_a_reg;
    assign res.reg_x       = out_x_reg;
    assign res.reg_y       = out_y_reg;
    assign res.stack_ptr   = out_sp_reg;
    assign res.status      = out_p_reg;
    assign res.mem_touched = out_touched_reg;
    assign res.mem_byte    = out_byte_reg;

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !out_valid_reg && !wait_reg)
        else $error("result or read in flight during clear sweep");
    a_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
        wait_reg && !can_finish |=> wait_reg && $stable(cur_reg))
        else $error("pending memory command lost while stalled");
    a_untouched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_touched_reg |-> out_byte_reg == 8'd0)
        else $error("memory byte reported without a write");

endmodule

// ----- hw/rtl/cpu8_load_store_alu_execute_unit.sv -----
// ============================================================================
// cpu8_load_store_alu_execute_unit
// Execute unit for a small 8-bit CPU: loads, stores, transfers, stack,
// increment/decrement, ADC/SBC, AND, EOR, with a private byte memory.
// ============================================================================
// Path: each command word is queued, then executed from the queue head into
//   the result register; PLA, PLP, INC and DEC first issue a memory read.
// Throughput: one word per cycle while the result side takes words, except
//   PLA, PLP, INC and DEC, during whose memory read no other word executes.
// Reset: registers go to A=X=Y=0, SP=0xFF, P=0x20; then a clear sweep zeroes
//   all MEM_DEPTH bytes of the memory, during which cmd.ready stays low.
module cpu8_load_store_alu_execute_unit #(
    parameter int MEM_DEPTH = cpu8_ex_pkg::MEM_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    cpu8_ex_cmd_if.sink   cmd,
    cpu8_ex_res_if.source res
);
    import cpu8_ex_pkg::*;

    // front -> queue
    logic   push;
    entry_t push_entry;

    // queue -> back
    logic   q_full;
    logic   q_valid;
    entry_t q_head;
    logic   pop;

    // back holds off the front while the memory clear sweep runs
    logic   clearing;

    // Front: take the command word, map unused codes to a no-op, flag the
    // commands that must read memory, and pre-compute the address quotient.
    cpu8_ex_front #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_front (
        .cmd        (cmd),
        .q_full     (q_full),
        .clearing   (clearing),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue: decouple acceptance from execution so the front keeps taking
    // words, up to two, while the back waits on memory or a stalled result.
    cpu8_ex_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    // Back: architectural registers, byte memory and the result register.
    cpu8_ex_back #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_entry  (q_head),
        .pop      (pop),
        .clearing (clearing),
        .res      (res)
    );

endmodule

// ----- verif/tb.sv -----
// ============================================================================
// tb
// Self-checking bench for the 8-bit CPU execute unit. A directed table comes
// first, then random instruction streams. Each snapshot word is checked
// field by field against a predictor of the register file and byte memory.
// ============================================================================
module tb;
    import cpu8_ex_pkg::*;

    localparam int               MEM_BYTES    = MEM_DEPTH_DEFAULT;
    localparam int               RANDOM_WORDS = 1200;
    localparam int               IDLE_PCT     = 31;
    localparam int               HOLD_CYCLES  = 300;
    localparam int               DRAIN_CYCLES = 8;
    localparam int               CYCLE_LIMIT  = 600000;
    localparam int               NUM_DRILL    = 28;
    localparam int               MAX_PRINTS   = 50;
    // Codes from here up to CMD_NOP carry no instruction and change nothing.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 5'd26;
    localparam logic [15:0]      STACK_BASE   = 16'h0100;

    // One snapshot word, as the result channel reports it.
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] p;
        logic       touched;
        logic [7:0] wbyte;
    } snapshot_t;

    // One row of the directed table. Where typed is set, want holds the
    // snapshot written out by hand; otherwise the predictor supplies it.
    typedef struct packed {
        logic [CMD_W-1:0] code;
        logic [7:0]       operand;
        logic [15:0]      addr;
        logic             typed;
        snapshot_t        want;
    } drill_row_t;

    logic clk = 1'b0;
    logic rst_n;

    cpu8_ex_cmd_if cmd_if ();
    cpu8_ex_res_if res_if ();

    cpu8_load_store_alu_execute_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor state: registers and a full image of the byte memory.
    // ------------------------------------------------------------------------
    logic [7:0]  acc;
    logic [7:0]  idx_x;
    logic [7:0]  idx_y;
    logic [7:0]  sp_img;
    logic [7:0]  psr;
    logic [7:0]  mem_img [0:MEM_BYTES-1];

    snapshot_t   pending_snapshots [$];
    logic [15:0] hot_addr [0:7];
    logic [7:0]  corner_bytes [0:3];

    int errors            = 0;
    int words_sent        = 0;
    int spare_sent        = 0;
    int stack_words       = 0;
    int rmw_words         = 0;
    int snapshots_checked = 0;
    int hold_reqs         = 0;
    int hold_done         = 0;
    int cycle_count       = 0;
    bit steady            = 1'b0;

    function automatic snapshot_t snap(logic [7:0] a, logic [7:0] x, logic [7:0] y,
                                       logic [7:0] sp, logic [7:0] p, logic touched,
                                       logic [7:0] wbyte);
        snapshot_t s;
        s.a       = a;
        s.x       = x;
        s.y       = y;
        s.sp      = sp;
        s.p       = p;
        s.touched = touched;
        s.wbyte   = wbyte;
        return s;
    endfunction

    task automatic clear_cpu_image();
        acc    = 8'h00;
        idx_x  = 8'h00;
        idx_y  = 8'h00;
        sp_img = STACK_RST;
        psr    = STATUS_RST;
        foreach (mem_img[i])
            mem_img[i] = 8'h00;
    endtask

    // Update Z and N from a produced value and pass the value through.
    function automatic logic [7:0] flag_zn(logic [7:0] v);
        psr = (psr & ~(FLAG_Z | FLAG_N)) | ((v == 8'h00) ? FLAG_Z : 8'h00) | (v & FLAG_N);
        return v;
    endfunction

    // Binary add of A, b and carry; SBC arrives here with b inverted.
    function automatic void add_with_carry(logic [7:0] b);
        logic [8:0] sum;
        logic [7:0] r;
        sum = {1'b0, acc} + {1'b0, b} + {8'h00, |(psr & FLAG_C)};
        r   = sum[7:0];
        psr = psr & ~(FLAG_C | FLAG_V);
        if (sum[8])
            psr = psr | FLAG_C;
        // Overflow: operands agree in sign and the sum does not.
        if (((~(acc ^ b)) & (acc ^ r) & 8'h80) != 8'h00)
            psr = psr | FLAG_V;
        acc = flag_zn(r);
    endfunction

    // Apply one command word to the predictor and return its snapshot.
    function automatic snapshot_t execute_word(logic [CMD_W-1:0] code, logic [7:0] operand,
                                               logic [15:0] addr);
        logic [15:0] ea;
        logic        wrote;
        logic [7:0]  wb;
        ea    = 16'(addr % MEM_BYTES);
        wrote = 1'b0;
        wb    = 8'h00;
        case (code)
            CMD_LDA: acc   = flag_zn(operand);
            CMD_LDX: idx_x = flag_zn(operand);
            CMD_LDY: idx_y = flag_zn(operand);
            CMD_STA:
            begin
                wb    = acc;
                wrote = 1'b1;
            end
            CMD_STX:
            begin
                wb    = idx_x;
                wrote = 1'b1;
            end
            CMD_STY:
            begin
                wb    = idx_y;
                wrote = 1'b1;
            end
            CMD_TAX: idx_x  = flag_zn(acc);
            CMD_TAY: idx_y  = flag_zn(acc);
            CMD_TSX: idx_x  = flag_zn(sp_img);
            CMD_TXA: acc    = flag_zn(idx_x);
            CMD_TXS: sp_img = idx_x;
            CMD_TYA: acc    = flag_zn(idx_y);
            CMD_PHA, CMD_PHP:
            begin
                // Write at the current slot, then move the pointer down.
                ea    = 16'((STACK_BASE + sp_img) % MEM_BYTES);
                wb    = (code == CMD_PHA) ? acc : (psr | FLAG_BRK);
                wrote = 1'b1;
                sp_img = sp_img - 8'd1;
            end
            CMD_PLA, CMD_PLP:
            begin
                // Move the pointer up first, then read.
                sp_img = sp_img + 8'd1;
                ea     = 16'((STACK_BASE + sp_img) % MEM_BYTES);
                if (code == CMD_PLA)
                    acc = flag_zn(mem_img[ea]);
                else
                    psr = (mem_img[ea] & PULL_MASK) | STATUS_ONE;
            end
            CMD_DEC:
            begin
                wb    = flag_zn(mem_img[ea] - 8'd1);
                wrote = 1'b1;
            end
            CMD_DEX: idx_x = flag_zn(idx_x - 8'd1);
            CMD_DEY: idx_y = flag_zn(idx_y - 8'd1);
            CMD_INC:
            begin
                wb    = flag_zn(mem_img[ea] + 8'd1);
                wrote = 1'b1;
            end
            CMD_INX: idx_x = flag_zn(idx_x + 8'd1);
            CMD_INY: idx_y = flag_zn(idx_y + 8'd1);
            CMD_ADC: add_with_carry(operand);
            CMD_SBC: add_with_carry(~operand);
            CMD_AND: acc = flag_zn(acc & operand);
            CMD_EOR: acc = flag_zn(acc ^ operand);
            default: ;
        endcase
        if (wrote)
            mem_img[ea] = wb;
        return snap(acc, idx_x, idx_y, sp_img, psr, wrote, wb);
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting: one line per mismatch, printing capped.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        if (errors < MAX_PRINTS)
            $display("[%0t] MISMATCH snapshot %0d %s: got 0x%02h want 0x%02h",
                     $time, snapshots_checked, what, got, want);
        errors++;
    endtask

    task automatic check_field(string what, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Command side. Drive at the rising edge, look for ready at the falling
    // edge (stable by then), and take the word at the next rising edge.
    // The predictor advances only once the word is actually taken.
    // ------------------------------------------------------------------------
    task automatic send_word(logic [CMD_W-1:0] code, logic [7:0] operand, logic [15:0] addr,
                             logic typed = 1'b0, snapshot_t want = '0);
        snapshot_t predicted;
        // Random idle cycles ahead of the word, none in the steady stretch.
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= code;
        cmd_if.value   <= operand;
        cmd_if.address <= addr;
        @(negedge clk);
        while (!cmd_if.ready)
            @(negedge clk);
        @(posedge clk);
        predicted = execute_word(code, operand, addr);
        pending_snapshots.push_back(typed ? want : predicted);
        if (code > CMD_EOR)
            spare_sent++;
        else
            words_sent++;
        if (code == CMD_PHA || code == CMD_PHP || code == CMD_PLA || code == CMD_PLP)
            stack_words++;
        if (code == CMD_INC || code == CMD_DEC)
            rmw_words++;
    endtask

    // Mostly reuse a small pool of addresses so stores, INC/DEC and the
    // stack keep meeting bytes that were written before.
    function automatic logic [15:0] pick_address();
        if ($urandom_range(99) < 70)
            return hot_addr[3'($urandom_range(7))];
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] pick_operand();
        if ($urandom_range(99) < 15)
            return corner_bytes[2'($urandom_range(3))];
        return 8'($urandom);
    endfunction

    // One random stretch of stimulus: a lone instruction, a push run
    // followed by its pulls, a load/store/modify chain on one byte, or noise.
    task automatic send_random_sequence();
        cmd_t        loads [0:2]  = '{CMD_LDA, CMD_LDX, CMD_LDY};
        cmd_t        stores [0:2] = '{CMD_STA, CMD_STX, CMD_STY};
        int          shape;
        int          depth;
        int          pick;
        logic [15:0] addr;
        shape = $urandom_range(99);
        if ($urandom_range(99) < 5)
            hot_addr[3'($urandom_range(7))] = 16'($urandom);
        if (shape < 60)
            send_word(CMD_W'($urandom_range(CMD_EOR)), pick_operand(), pick_address());
        else if (shape < 78)
        begin
            depth = $urandom_range(4, 1);
            repeat (depth)
                send_word($urandom_range(1) ? CMD_PHA : CMD_PHP, pick_operand(),
                          pick_address());
            repeat (depth)
                send_word($urandom_range(1) ? CMD_PLA : CMD_PLP, pick_operand(),
                          pick_address());
        end
        else if (shape < 95)
        begin
            addr = pick_address();
            pick = $urandom_range(2);
            send_word(loads[pick], pick_operand(), addr);
            send_word(stores[pick], pick_operand(), addr);
            repeat ($urandom_range(3, 1))
                send_word($urandom_range(1) ? CMD_INC : CMD_DEC, pick_operand(), addr);
        end
        else
            send_word(CMD_W'($urandom_range(CMD_NOP, CMD_SPARE_LO)), 8'($urandom),
                      16'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Result side: random ready, plus a long hold-off on request. The hold
    // is counted here so the command side keeps offering words meanwhile.
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_done != hold_reqs)
            begin
                hold_done = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else
                res_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Check each taken snapshot against the oldest pending one. Sample at
    // the falling edge, where valid and ready hold what the next rising
    // edge will see.
    initial
    begin
        snapshot_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
            begin
                if (pending_snapshots.size() == 0)
                    report_mismatch("snapshot with nothing pending", 8'h00, 8'h00);
                else
                begin
                    want = pending_snapshots.pop_front();
                    check_field("reg_a", res_if.reg_a, want.a);
                    check_field("reg_x", res_if.reg_x, want.x);
                    check_field("reg_y", res_if.reg_y, want.y);
                    check_field("stack_ptr", res_if.stack_ptr, want.sp);
                    check_field("status", res_if.status, want.p);
                    check_field("mem_touched", {7'd0, res_if.mem_touched},
                                {7'd0, want.touched});
                    check_field("mem_byte", res_if.mem_byte, want.wbyte);
                    snapshots_checked++;
                end
            end
        end
    end

    // Watchdog: the memory clear sweep after reset plus a wide margin for
    // the slowest legal run with every stall and hold-off.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[%0t] timeout after %0d cycles, %0d snapshots still pending",
                 $time, cycle_count, pending_snapshots.size());
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        drill_row_t drill_table [0:NUM_DRILL-1];
        int         base;
        int         done;
        int         hold_marks;
        bit         paused;

        // Hold every input at a known value from time zero.
        rst_n          <= 1'b0;
        cmd_if.valid   <= 1'b0;
        cmd_if.command <= CMD_NOP;
        cmd_if.value   <= 8'h00;
        cmd_if.address <= 16'h0000;

        clear_cpu_image();
        corner_bytes = '{8'h00, 8'h7f, 8'h80, 8'hff};
        hot_addr     = '{16'h0000, 16'hffff, 16'h01ff, STACK_BASE,
                         16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};

        // Directed table. The first rows are read straight off the reset
        // state; from INC on, the predictor carries the expectation.
        drill_table = '{
            '{CMD_NOP, 8'h00, 16'h0000, 1'b1,
              snap(8'h00, 8'h00, 8'h00, 8'hff, 8'h20, 1'b0, 8'h00)},
            '{CMD_LDA, 8'h00, 16'h0000, 1'b1,
              snap(8'h00, 8'h00, 8'h00, 8'hff, 8'h22, 1'b0, 8'h00)},
            '{CMD_LDX, 8'hff, 16'h0000, 1'b1,
              snap(8'h00, 8'hff, 8'h00, 8'hff, 8'ha0, 1'b0, 8'h00)},
            '{CMD_LDY, 8'h80, 16'h0000, 1'b1,
              snap(8'h00, 8'hff, 8'h80, 8'hff, 8'ha0, 1'b0, 8'h00)},
            '{CMD_STA, 8'h00, 16'hffff, 1'b1,
              snap(8'h00, 8'hff, 8'h80, 8'hff, 8'ha0, 1'b1, 8'h00)},
            '{CMD_STX, 8'h00, 16'h0000, 1'b1,
              snap(8'h00, 8'hff, 8'h80, 8'hff, 8'ha0, 1'b1, 8'hff)},
            '{CMD_STY, 8'h00, 16'h1234, 1'b1,
              snap(8'h00, 8'hff, 8'h80, 8'hff, 8'ha0, 1'b1, 8'h80)},
            '{CMD_INC, 8'h00, 16'hffff, 1'b0, '0},
            '{CMD_DEC, 8'h00, 16'h0000, 1'b0, '0},
            '{CMD_TAX, 8'h00, 16'h0000, 1'b0, '0},
            '{CMD_TAY, 8'h00, 16'h0000, 1'b0, '0},
            '{CMD_TSX, 8'h00, 16'h0000, 1'b0, '0},
            '{CMD_TXA, 8'h00, 16'h0000, 1'b0, '0},
            '{CMD_TXS, 8'h00, 16'h0000, 1'b0, '0},
            '{CMD_TYA, 8'h00, 16'h0000, 1'b0, '0},
            '{CMD_PHA, 8'h00, 16'h0000, 1'b0, '0},
            '{CMD_PHP, 8'h00, 16'h0000, 1'b0, '0},
            '{CMD_PLA, 8'h00, 16'h0000, 1'b0, '0},
            '{CMD_PLP, 8'h00, 16'h0000, 1'b0, '0},
            '{CMD_DEX, 8'h00, 16'h0000, 1'b0, '0},
            '{CMD_DEY, 8'h00, 16'h0000, 1'b0, '0},
            '{CMD_INX, 8'h00, 16'h0000, 1'b0, '0},
            '{CMD_INY, 8'h00, 16'h0000, 1'b0, '0},
            '{CMD_ADC, 8'h7f, 16'h0000, 1'b0, '0},
            '{CMD_SBC, 8'h80, 16'h0000, 1'b0, '0},
            '{CMD_AND, 8'h0f, 16'h0000, 1'b0, '0},
            '{CMD_EOR, 8'hff, 16'h0000, 1'b0, '0},
            '{CMD_SPARE_LO, 8'hff, 16'hffff, 1'b0, '0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The first word waits out the memory clear sweep on cmd.ready.
        foreach (drill_table[i])
            send_word(drill_table[i].code, drill_table[i].operand, drill_table[i].addr,
                      drill_table[i].typed, drill_table[i].want);

        // Random streams. Along the way: two long hold-offs on the result
        // side while words keep coming, one full drain with the command
        // side paused, and a stretch with no idling on either side.
        base       = words_sent;
        hold_marks = 0;
        paused     = 1'b0;
        done       = 0;
        while (done < RANDOM_WORDS)
        begin
            steady = (done >= 700 && done < 850);
            if (hold_marks < 2 && done >= 300 + 700 * hold_marks)
            begin
                hold_reqs++;
                hold_marks++;
            end
            if (!paused && done >= 600)
            begin
                // Drop valid and hold until every pending snapshot is back.
                cmd_if.valid <= 1'b0;
                @(posedge clk);
                while (pending_snapshots.size() != 0)
                    @(posedge clk);
                paused = 1'b1;
            end
            send_random_sequence();
            done = words_sent - base;
        end
        steady = 1'b0;
        cmd_if.valid <= 1'b0;

        // Drain, then give the block a few more cycles to show any stray word.
        while (pending_snapshots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d instruction words plus %0d with unused codes: %0d stack, %0d INC/DEC",
                 words_sent, spare_sent, stack_words, rmw_words);
        $display("Compared %0d snapshots field by field, %0d mismatches, %0d cycles",
                 snapshots_checked, errors, cycle_count);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
